// ===== hdl/rotary_position_embedding_defines.svh =====
// Assertion macros for the rotary position embedding block.
`ifndef ROTARY_POSITION_EMBEDDING_DEFINES_SVH
`define ROTARY_POSITION_EMBEDDING_DEFINES_SVH
`ifndef SYNTH
// Same-cycle implication, checked out of reset.
`define RPE_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: check failed");
// Next-cycle implication, checked out of reset.
`define RPE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: check failed");
`else
`define RPE_ASSERT_NOW(lbl, clk, rst_n, ante, cons)
`define RPE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ===== hdl/rope_pkg.sv =====
// Shared constants and types of the rotary position embedding block.
package rope_pkg;

    localparam int DEF_MAX_HEAD   = 256;
    localparam int DEF_MAX_PAIRS  = 128;
    localparam int DEF_DATA_WIDTH = 16;

    // Hard limits set by the 8-bit element index.
    localparam int HW_PAIR_LIMIT = 128;
    localparam int HW_HEAD_LIMIT = 256;

    localparam int IDX_W      = 8;
    localparam int PC_W       = 8;
    localparam int HL_W       = 9;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 9;

    localparam logic [CFG_IDX_W-1:0] REG_PAIR_COUNT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HEAD_LEN    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ROTATE_HALF = 2'd2;

    localparam logic [PC_W-1:0] RST_PAIR_COUNT  = 8'd64;
    localparam logic [HL_W-1:0] RST_HEAD_LEN    = 9'd128;
    localparam logic            RST_ROTATE_HALF = 1'b1;

    typedef struct packed {
        logic             pair;
        logic [IDX_W-1:0] lo_index;
        logic [IDX_W-1:0] hi_index;
        logic             last;
    } t_result_ctl;

endpackage

// ===== hdl/rope_buf.sv =====
// Pair buffer: single-port-write, registered-read memory of first pair elements.
module rope_buf #(
    parameter int DEPTH      = rope_pkg::DEF_MAX_PAIRS,
    parameter int ADDR_W     = 7,
    parameter int DATA_WIDTH = rope_pkg::DEF_DATA_WIDTH
) (
    input  logic                  i_clk,
    input  logic                  i_wr_en,
    input  logic [ADDR_W-1:0]     i_wr_addr,
    input  logic [DATA_WIDTH-1:0] i_wr_data,
    input  logic                  i_rd_en,
    input  logic [ADDR_W-1:0]     i_rd_addr,
    output logic [DATA_WIDTH-1:0] o_rd_data
);

    logic [DATA_WIDTH-1:0] r_mem [DEPTH];
    logic [DATA_WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        // hold the read word until the next read
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== hdl/rope_seq.sv =====
// Configuration registers, element counter and per-element pair decode.
module rope_seq #(
    parameter int MAX_HEAD  = rope_pkg::DEF_MAX_HEAD,
    parameter int MAX_PAIRS = rope_pkg::DEF_MAX_PAIRS,
    parameter int ADDR_W    = 7
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_wr,
    input  logic [rope_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [rope_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic                               i_advance,
    output logic                               o_emit,
    output logic                               o_wr_en,
    output logic                               o_rd_en,
    output logic [ADDR_W-1:0]                  o_slot,
    output rope_pkg::t_result_ctl              o_ctl
);

    localparam int NP_LIM_I  = (MAX_PAIRS < rope_pkg::HW_PAIR_LIMIT) ?
                               MAX_PAIRS : rope_pkg::HW_PAIR_LIMIT;
    localparam int LEN_LIM_I = (MAX_HEAD < rope_pkg::HW_HEAD_LIMIT) ?
                               MAX_HEAD : rope_pkg::HW_HEAD_LIMIT;
    localparam logic [rope_pkg::PC_W-1:0] NP_LIM  = rope_pkg::PC_W'(NP_LIM_I);
    localparam logic [rope_pkg::HL_W-1:0] LEN_LIM = rope_pkg::HL_W'(LEN_LIM_I);

    logic [rope_pkg::PC_W-1:0]  r_pair_count;
    logic [rope_pkg::HL_W-1:0]  r_head_len;
    logic                       r_rotate_half;
    logic [rope_pkg::IDX_W-1:0] r_count;
    logic [rope_pkg::IDX_W-1:0] n_count;

    logic [rope_pkg::PC_W-1:0]  w_np;
    logic [rope_pkg::HL_W-1:0]  w_two_np;
    logic [rope_pkg::HL_W-1:0]  w_len0;
    logic [rope_pkg::HL_W-1:0]  w_len1;
    logic [rope_pkg::HL_W-1:0]  w_len;
    logic                       w_last;
    logic                       w_pass;
    logic                       w_second;
    logic [rope_pkg::IDX_W-1:0] w_slot;
    logic [rope_pkg::IDX_W-1:0] w_lo_idx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pair_count  <= rope_pkg::RST_PAIR_COUNT;
            r_head_len    <= rope_pkg::RST_HEAD_LEN;
            r_rotate_half <= rope_pkg::RST_ROTATE_HALF;
        end else if (i_cfg_wr) begin
            case (i_cfg_index)
                rope_pkg::REG_PAIR_COUNT:  r_pair_count  <= i_cfg_data[rope_pkg::PC_W-1:0];
                rope_pkg::REG_HEAD_LEN:    r_head_len    <= i_cfg_data[rope_pkg::HL_W-1:0];
                rope_pkg::REG_ROTATE_HALF: r_rotate_half <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // effective pair count and head length
    always_comb begin
        w_np     = (r_pair_count > NP_LIM) ? NP_LIM : r_pair_count;
        w_two_np = {w_np, 1'b0};
        w_len0   = (r_head_len < w_two_np) ? w_two_np : r_head_len;
        w_len1   = (w_len0 == '0) ? rope_pkg::HL_W'(1) : w_len0;
        w_len    = (w_len1 > LEN_LIM) ? LEN_LIM : w_len1;
    end

    always_comb begin
        w_last = ({1'b0, r_count} + rope_pkg::HL_W'(1)) >= w_len;
        w_pass = {1'b0, r_count} >= w_two_np;
        if (r_rotate_half) begin
            w_second = r_count >= w_np;
            w_slot   = w_second ? (r_count - w_np) : r_count;
            w_lo_idx = w_slot;
        end else begin
            w_second = r_count[0];
            w_slot   = {1'b0, r_count[rope_pkg::IDX_W-1:1]};
            w_lo_idx = {r_count[rope_pkg::IDX_W-1:1], 1'b0};
        end
        n_count = w_last ? '0 : (r_count + rope_pkg::IDX_W'(1));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_advance) begin
            r_count <= n_count;
        end
    end

    assign o_emit          = w_pass || w_second;
    assign o_wr_en         = !w_pass && !w_second;
    assign o_rd_en         = !w_pass && w_second;
    assign o_slot          = ADDR_W'(w_slot);
    assign o_ctl.pair      = !w_pass;
    assign o_ctl.lo_index  = w_pass ? r_count : w_lo_idx;
    assign o_ctl.hi_index  = r_count;
    assign o_ctl.last      = w_last;

endmodule

// ===== hdl/rope_rot.sv =====
// Rotation pipeline: operand stage, product stage, round/saturate and output stage.
`include "rotary_position_embedding_defines.svh"

module rope_rot #(
    parameter int DATA_WIDTH = rope_pkg::DEF_DATA_WIDTH
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_load,
    input  rope_pkg::t_result_ctl             i_ctl,
    input  logic signed [DATA_WIDTH-1:0]      i_y,
    input  logic signed [DATA_WIDTH-1:0]      i_c,
    input  logic signed [DATA_WIDTH-1:0]      i_s,
    input  logic signed [DATA_WIDTH-1:0]      i_x,
    output logic                              o_busy,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic [rope_pkg::IDX_W-1:0]        o_out_index,
    output logic signed [DATA_WIDTH-1:0]      o_out_value,
    output logic                              o_run_end,
    output logic                              o_head_done
);

    localparam int PW = 2 * DATA_WIDTH;
    localparam int SW = PW + 1;
    localparam int RW = SW - (DATA_WIDTH - 1);
    localparam logic signed [SW-1:0] HALF =
        {{(SW - DATA_WIDTH + 1){1'b0}}, 1'b1, {(DATA_WIDTH - 2){1'b0}}};
    localparam logic signed [DATA_WIDTH-1:0] MAXV = {1'b0, {(DATA_WIDTH - 1){1'b1}}};
    localparam logic signed [DATA_WIDTH-1:0] MINV = {1'b1, {(DATA_WIDTH - 1){1'b0}}};

    function automatic logic signed [DATA_WIDTH-1:0] round_sat(
        input logic signed [SW-1:0] sum
    );
        logic signed [SW-1:0] biased;
        logic        [RW-1:0] q;
        biased = sum + HALF;
        q      = biased[SW-1:DATA_WIDTH-1];
        // saturate when the bits above the result are not a sign extension
        if ((q[RW-1:DATA_WIDTH-1] != '0) && (q[RW-1:DATA_WIDTH-1] != '1)) begin
            round_sat = q[RW-1] ? MINV : MAXV;
        end else begin
            round_sat = q[DATA_WIDTH-1:0];
        end
    endfunction

    // operand stage (buffer read data arrives here)
    logic                          r_v1;
    rope_pkg::t_result_ctl         r_ctl1;
    logic signed [DATA_WIDTH-1:0]  r_y1;
    logic signed [DATA_WIDTH-1:0]  r_c1;
    logic signed [DATA_WIDTH-1:0]  r_s1;

    // product stage
    logic                          r_v2;
    rope_pkg::t_result_ctl         r_ctl2;
    logic signed [DATA_WIDTH-1:0]  r_y2;
    logic signed [PW-1:0]          r_xc2;
    logic signed [PW-1:0]          r_ys2;
    logic signed [PW-1:0]          r_xs2;
    logic signed [PW-1:0]          r_yc2;

    // output stage
    logic                          r_o_valid;
    logic                          r_o_phase;
    rope_pkg::t_result_ctl         r_o_ctl;
    logic signed [DATA_WIDTH-1:0]  r_o_lo;
    logic signed [DATA_WIDTH-1:0]  r_o_hi;

    logic                          w_fire;
    logic                          w_ready1;
    logic                          w_ready2;
    logic                          w_ready3;
    logic signed [SW-1:0]          w_lo_sum;
    logic signed [SW-1:0]          w_hi_sum;

    always_comb begin
        w_fire   = r_o_valid && !i_stall;
        w_ready3 = !r_o_valid || (w_fire && (r_o_phase || !r_o_ctl.pair));
        w_ready2 = !r_v2 || w_ready3;
        w_ready1 = !r_v1 || w_ready2;
        w_lo_sum = SW'(r_xc2) - SW'(r_ys2);
        w_hi_sum = SW'(r_xs2) + SW'(r_yc2);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1      <= 1'b0;
            r_v2      <= 1'b0;
            r_o_valid <= 1'b0;
            r_o_phase <= 1'b0;
        end else begin
            if (w_ready1) begin
                r_v1 <= i_load;
            end
            if (w_ready2) begin
                r_v2 <= r_v1;
            end
            if (w_ready3) begin
                r_o_valid <= r_v2;
                r_o_phase <= 1'b0;
            end else if (w_fire) begin
                // lower result taken, present the upper one
                r_o_phase <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load && w_ready1) begin
            r_ctl1 <= i_ctl;
            r_y1   <= i_y;
            r_c1   <= i_c;
            r_s1   <= i_s;
        end
        if (r_v1 && w_ready2) begin
            r_ctl2 <= r_ctl1;
            r_y2   <= r_y1;
            r_xc2  <= i_x * r_c1;
            r_ys2  <= r_y1 * r_s1;
            r_xs2  <= i_x * r_s1;
            r_yc2  <= r_y1 * r_c1;
        end
        if (r_v2 && w_ready3) begin
            r_o_ctl <= r_ctl2;
            r_o_lo  <= r_ctl2.pair ? round_sat(w_lo_sum) : r_y2;
            r_o_hi  <= round_sat(w_hi_sum);
        end
    end

    assign o_busy      = !w_ready1;
    assign o_valid     = r_o_valid;
    assign o_out_index = (r_o_ctl.pair && r_o_phase) ? r_o_ctl.hi_index : r_o_ctl.lo_index;
    assign o_out_value = r_o_phase ? r_o_hi : r_o_lo;
    assign o_run_end   = !r_o_ctl.pair || r_o_phase;
    assign o_head_done = (!r_o_ctl.pair || r_o_phase) && r_o_ctl.last;

    `RPE_ASSERT_NOW(a_phase_only_pair, i_clk, i_rst_n, r_o_valid && r_o_phase, r_o_ctl.pair)
    `RPE_ASSERT_NEXT(a_upper_follows, i_clk, i_rst_n, w_fire && r_o_ctl.pair && !r_o_phase, r_o_valid && r_o_phase)
    `RPE_ASSERT_NEXT(a_stage2_holds, i_clk, i_rst_n, r_v2 && !w_ready3, r_v2)

endmodule

// ===== hdl/rotary_position_embedding.sv =====
// Rotary position embedding top level: streams head elements, rotates pairs, passes the rest.
// Results are registered through the operand, product and output registers; the upper result of a
//   pair follows in the cycle after the lower one is taken.
// Throughput: one element per cycle while o_stall is low; the single output register gives one result
//   per cycle while i_stall is low, so a run of pair-completing elements raises o_stall.
// Reset: synchronous, active low; counter to zero, registers to their defaults, pipeline empty.
//   The pair buffer is not cleared and needs no clearing pass.
module rotary_position_embedding #(
    parameter int MAX_HEAD   = rope_pkg::DEF_MAX_HEAD,
    parameter int MAX_PAIRS  = rope_pkg::DEF_MAX_PAIRS,
    parameter int DATA_WIDTH = rope_pkg::DEF_DATA_WIDTH
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [rope_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [rope_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic                               i_valid,
    output logic                               o_stall,
    input  logic signed [DATA_WIDTH-1:0]       i_elem_value,
    input  logic signed [DATA_WIDTH-1:0]       i_cos_value,
    input  logic signed [DATA_WIDTH-1:0]       i_sin_value,
    output logic                               o_valid,
    input  logic                               i_stall,
    output logic [rope_pkg::IDX_W-1:0]         o_out_index,
    output logic signed [DATA_WIDTH-1:0]       o_out_value,
    output logic                               o_run_end,
    output logic                               o_head_done
);

    localparam int ADDR_W = (MAX_PAIRS > 1) ? $clog2(MAX_PAIRS) : 1;

    logic                            w_accept;
    logic                            w_busy;
    logic                            w_emit;
    logic                            w_wr_en;
    logic                            w_rd_en;
    logic [ADDR_W-1:0]               w_slot;
    rope_pkg::t_result_ctl           w_ctl;
    logic signed [DATA_WIDTH-1:0]    w_x;

    assign o_cfg_ready = 1'b1;
    assign o_stall     = w_busy;
    assign w_accept    = i_valid && !w_busy;

    rope_seq #(
        .MAX_HEAD  (MAX_HEAD),
        .MAX_PAIRS (MAX_PAIRS),
        .ADDR_W    (ADDR_W)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr    (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_advance   (w_accept),
        .o_emit      (w_emit),
        .o_wr_en     (w_wr_en),
        .o_rd_en     (w_rd_en),
        .o_slot      (w_slot),
        .o_ctl       (w_ctl)
    );

    rope_buf #(
        .DEPTH      (MAX_PAIRS),
        .ADDR_W     (ADDR_W),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_buf (
        .i_clk     (i_clk),
        .i_wr_en   (w_accept && w_wr_en),
        .i_wr_addr (w_slot),
        .i_wr_data (i_elem_value),
        .i_rd_en   (w_accept && w_rd_en),
        .i_rd_addr (w_slot),
        .o_rd_data (w_x)
    );

    rope_rot #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_rot (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (w_accept && w_emit),
        .i_ctl       (w_ctl),
        .i_y         (i_elem_value),
        .i_c         (i_cos_value),
        .i_s         (i_sin_value),
        .i_x         (w_x),
        .o_busy      (w_busy),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_out_index (o_out_index),
        .o_out_value (o_out_value),
        .o_run_end   (o_run_end),
        .o_head_done (o_head_done)
    );

endmodule

// ===== bench/rotary_position_embedding_tb.sv =====
// Testbench for the streaming rotary position embedding block: predicted results, checked in order.
`timescale 1ns / 1ps

module rotary_position_embedding_tb;

    localparam int CYCLE_LIMIT    = 500000;
    localparam int SETTLE_CYCLES  = 8;
    localparam int LONG_HOLD      = 300;
    localparam int RANDOM_ELEMS   = 1300;
    localparam int MAX_REPORTS    = 100;

    // Index that no register answers to.
    localparam logic [rope_pkg::CFG_IDX_W-1:0] REG_SPARE = 2'd3;

    localparam logic signed [15:0] S16_MAX = 16'sh7fff;
    localparam logic signed [15:0] S16_MIN = 16'sh8000;

    typedef enum int {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY,
        STALL_PERIODIC
    } t_stall_mode;

    typedef struct packed {
        logic [rope_pkg::IDX_W-1:0] index;
        logic signed [15:0]         value;
        logic                       run_end;
        logic                       head_done;
    } t_rope_result;

    logic                            i_clk = 1'b0;
    logic                            i_rst_n = 1'b0;
    logic                            i_cfg_valid = 1'b0;
    logic                            o_cfg_ready;
    logic [rope_pkg::CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [rope_pkg::CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                            i_valid = 1'b0;
    logic                            o_stall;
    logic signed [15:0]              i_elem_value = '0;
    logic signed [15:0]              i_cos_value = '0;
    logic signed [15:0]              i_sin_value = '0;
    logic                            o_valid;
    logic                            i_stall = 1'b0;
    logic [rope_pkg::IDX_W-1:0]      o_out_index;
    logic signed [15:0]              o_out_value;
    logic                            o_run_end;
    logic                            o_head_done;

    rotary_position_embedding uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_elem_value (i_elem_value),
        .i_cos_value  (i_cos_value),
        .i_sin_value  (i_sin_value),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_out_index  (o_out_index),
        .o_out_value  (o_out_value),
        .o_run_end    (o_run_end),
        .o_head_done  (o_head_done)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Predictor state: register copies, pair buffer and element counter.
    logic [rope_pkg::PC_W-1:0] cfg_pairs = rope_pkg::RST_PAIR_COUNT;
    logic [rope_pkg::HL_W-1:0] cfg_head_len = rope_pkg::RST_HEAD_LEN;
    logic                      cfg_rot_half = rope_pkg::RST_ROTATE_HALF;
    logic signed [15:0]        buf_slot [0:rope_pkg::DEF_MAX_PAIRS-1];
    int                        head_pos = 0;

    t_rope_result pending_results[$];

    int  error_count = 0;
    int  elems_sent = 0;
    int  burst_left = 0;
    int  cycle_count = 0;
    bit  hold_req = 1'b0;

    function automatic int pair_span();
        int np;
        np = int'(cfg_pairs);
        if (np > rope_pkg::DEF_MAX_PAIRS) np = rope_pkg::DEF_MAX_PAIRS;
        if (np > rope_pkg::HW_PAIR_LIMIT) np = rope_pkg::HW_PAIR_LIMIT;
        return np;
    endfunction

    function automatic int head_span();
        int np;
        int len;
        np = pair_span();
        len = int'(cfg_head_len);
        if (len < 2 * np) len = 2 * np;
        if (len < 1) len = 1;
        if (len > rope_pkg::DEF_MAX_HEAD) len = rope_pkg::DEF_MAX_HEAD;
        if (len > rope_pkg::HW_HEAD_LIMIT) len = rope_pkg::HW_HEAD_LIMIT;
        return len;
    endfunction

    // Round half up, drop 15 fraction bits, saturate to 16 bits.
    function automatic logic signed [15:0] round_sat(longint p1, longint p2);
        longint acc;
        acc = (p1 + p2 + 64'sd16384) >>> 15;
        if (acc > 32767) acc = 32767;
        else if (acc < -32768) acc = -32768;
        return acc[15:0];
    endfunction

    function automatic void queue_result(int idx, logic signed [15:0] val, bit run_end,
                                         bit head_done);
        t_rope_result r;
        r.index     = idx[rope_pkg::IDX_W-1:0];
        r.value     = val;
        r.run_end   = run_end;
        r.head_done = head_done;
        pending_results.push_back(r);
    endfunction

    function automatic void rotate_step(logic signed [15:0] v, logic signed [15:0] c,
                                        logic signed [15:0] s);
        int     np;
        int     idx;
        int     slot;
        int     lo_idx;
        bit     second;
        bit     last;
        longint x;
        longint y;
        np   = pair_span();
        idx  = head_pos;
        last = (idx + 1 >= head_span());
        if (idx >= 2 * np) begin
            queue_result(idx, v, 1'b1, last);
        end else begin
            if (cfg_rot_half) begin
                second = (idx >= np);
                slot   = second ? idx - np : idx;
                lo_idx = slot;
            end else begin
                second = idx[0];
                slot   = idx >> 1;
                lo_idx = idx & ~1;
            end
            if (!second) begin
                buf_slot[slot] = v;
            end else begin
                x = longint'(buf_slot[slot]);
                y = longint'(v);
                queue_result(lo_idx, round_sat(x * longint'(c), -(y * longint'(s))),
                             1'b0, 1'b0);
                queue_result(idx, round_sat(x * longint'(s), y * longint'(c)), 1'b1, last);
            end
        end
        head_pos = last ? 0 : ((idx + 1) & 255);
    endfunction

    function automatic void apply_write(logic [rope_pkg::CFG_IDX_W-1:0] idx,
                                        logic [rope_pkg::CFG_DATA_W-1:0] data);
        case (idx)
            rope_pkg::REG_PAIR_COUNT:  cfg_pairs = data[rope_pkg::PC_W-1:0];
            rope_pkg::REG_HEAD_LEN:    cfg_head_len = data[rope_pkg::HL_W-1:0];
            rope_pkg::REG_ROTATE_HALF: cfg_rot_half = data[0];
            default: ;
        endcase
    endfunction

    function automatic logic signed [15:0] rand_sample();
        case ($urandom_range(0, 9))
            0: return S16_MIN;
            1: return S16_MAX;
            2: return 16'shffff;
            3: return 16'sh0000;
            default: return 16'($urandom());
        endcase
    endfunction

    task automatic report_mismatch(string what);
        if (error_count < MAX_REPORTS)
            $display("%0t: mismatch: %s", $time, what);
        error_count++;
    endtask

    always @(posedge i_clk) begin : result_check
        t_rope_result want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_results.size() == 0) begin
                report_mismatch($sformatf("unexpected result index %0d value %0d",
                                          o_out_index, o_out_value));
            end else begin
                want = pending_results.pop_front();
                if (o_out_index !== want.index)
                    report_mismatch($sformatf("index %0d, want %0d", o_out_index, want.index));
                if (o_out_value !== want.value)
                    report_mismatch($sformatf("value %0d at index %0d, want %0d",
                                              o_out_value, want.index, want.value));
                if (o_run_end !== want.run_end)
                    report_mismatch($sformatf("run_end %b at index %0d, want %b",
                                              o_run_end, want.index, want.run_end));
                if (o_head_done !== want.head_done)
                    report_mismatch($sformatf("head_done %b at index %0d, want %b",
                                              o_head_done, want.index, want.head_done));
            end
        end
    end

    // Receiver: change stall pattern now and then; hold off for a long stretch on request.
    always @(posedge i_clk) begin : stall_gen
        int          hold_left;
        int          mode_left;
        t_stall_mode stall_mode;
        if (hold_req) begin
            hold_req = 1'b0;
            hold_left = LONG_HOLD;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_stall <= 1'b1;
        end else begin
            if (mode_left == 0) begin
                stall_mode = t_stall_mode'($urandom_range(0, 3));
                mode_left = $urandom_range(20, 300);
            end else begin
                mode_left--;
            end
            case (stall_mode)
                STALL_NONE:  i_stall <= 1'b0;
                STALL_LIGHT: i_stall <= ($urandom_range(0, 3) == 0);
                STALL_HEAVY: i_stall <= ($urandom_range(0, 3) != 0);
                default:     i_stall <= (mode_left % 3 == 0);
            endcase
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic send_elem(logic signed [15:0] v, logic signed [15:0] c, logic signed [15:0] s);
        i_valid      <= 1'b1;
        i_elem_value <= v;
        i_cos_value  <= c;
        i_sin_value  <= s;
        do @(posedge i_clk); while (o_stall);
        rotate_step(v, c, s);
        elems_sent++;
    endtask

    // Send one request, then idle a random gap at the end of a burst.
    task automatic feed(logic signed [15:0] v, logic signed [15:0] c, logic signed [15:0] s);
        int gap;
        send_elem(v, c, s);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end else begin
            burst_left--;
        end
    endtask

    task automatic feed_random();
        feed(rand_sample(), rand_sample(), rand_sample());
    endtask

    task automatic stream_head();
        do feed_random(); while (head_pos != 0);
    endtask

    // Drop valid, wait for every outstanding result, then let buffering-only requests clear.
    task automatic settle();
        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic cfg_write(logic [rope_pkg::CFG_IDX_W-1:0] idx,
                             logic [rope_pkg::CFG_DATA_W-1:0] data, bit keep);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        apply_write(idx, data);
        if (!keep) i_cfg_valid <= 1'b0;
    endtask

    task automatic set_config(int pc, int hl, bit rh);
        logic [rope_pkg::CFG_DATA_W-1:0] pc_word;
        logic [rope_pkg::CFG_DATA_W-1:0] rh_word;
        settle();
        // Spare upper bits carry noise; the block must mask them.
        pc_word = rope_pkg::CFG_DATA_W'(pc);
        pc_word[rope_pkg::PC_W] = 1'($urandom_range(0, 1));
        rh_word = rope_pkg::CFG_DATA_W'($urandom_range(0, 511));
        rh_word[0] = rh;
        cfg_write(rope_pkg::REG_PAIR_COUNT, pc_word, 1'b1);
        cfg_write(rope_pkg::REG_HEAD_LEN, rope_pkg::CFG_DATA_W'(hl), 1'b1);
        cfg_write(rope_pkg::REG_ROTATE_HALF, rh_word, 1'b0);
    endtask

    task automatic test_adjacent_pairs();
        set_config(2, 5, 1'b0);
        feed(S16_MAX, rand_sample(), rand_sample());
        feed(S16_MIN, S16_MIN, S16_MIN);
        feed(S16_MIN, rand_sample(), rand_sample());
        feed(S16_MIN, S16_MIN, S16_MAX);
        feed(16'shffff, rand_sample(), rand_sample());
    endtask

    task automatic test_rotate_half_pairs();
        set_config(2, 4, 1'b1);
        feed(S16_MAX, S16_MAX, S16_MIN);
        feed(16'sh1234, S16_MIN, S16_MAX);
        feed(S16_MAX, S16_MAX, S16_MAX);
        feed(S16_MIN, 16'sh5a82, 16'sh5a82);
    endtask

    task automatic test_pair_count_zero();
        // No pairs and a zero head length: every element is a head of its own.
        set_config(0, 0, 1'b1);
        feed_random();
        feed_random();
    endtask

    task automatic test_short_head();
        set_config(3, 1, 1'b0);
        stream_head();
    endtask

    task automatic test_mid_head_change();
        set_config(1, 4, 1'b0);
        repeat (3) feed_random();
        // Shrink the head below the counter: the next element ends it.
        settle();
        cfg_write(rope_pkg::REG_HEAD_LEN, 9'd2, 1'b0);
        feed_random();
    endtask

    task automatic test_unknown_register();
        set_config(1, 2, 1'b0);
        stream_head();
        settle();
        cfg_write(REG_SPARE, '1, 1'b0);
        stream_head();
    endtask

    task automatic test_backpressure();
        set_config(8, 48, 1'b0);
        hold_req = 1'b1;
        stream_head();
        stream_head();
    endtask

    task automatic pick_config(output int pc, output int hl);
        int r;
        int np;
        r = $urandom_range(0, 19);
        if (r < 13)      pc = $urandom_range(1, 16);
        else if (r < 16) pc = $urandom_range(17, 128);
        else if (r < 18) pc = $urandom_range(129, 255);
        else             pc = 0;
        np = (pc > rope_pkg::HW_PAIR_LIMIT) ? rope_pkg::HW_PAIR_LIMIT : pc;
        r = $urandom_range(0, 19);
        if (r < 12)      hl = 2 * np + $urandom_range(0, 6);
        else if (r < 17) hl = $urandom_range(0, 40);
        else             hl = $urandom_range(0, 511);
    endtask

    task automatic test_random_heads();
        int pc;
        int hl;
        int goal;
        goal = elems_sent + RANDOM_ELEMS;
        // The widest head writes every buffer slot, so later mid-head changes read written data.
        set_config(rope_pkg::HW_PAIR_LIMIT, rope_pkg::HW_HEAD_LIMIT, 1'b1);
        stream_head();
        while (elems_sent < goal) begin
            pick_config(pc, hl);
            set_config(pc, hl, 1'($urandom_range(0, 1)));
            if ($urandom_range(0, 3) == 0) begin
                repeat ($urandom_range(1, head_span())) feed_random();
                pick_config(pc, hl);
                set_config(pc, hl, 1'($urandom_range(0, 1)));
            end
            repeat ($urandom_range(1, 3)) stream_head();
        end
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_adjacent_pairs();
        test_rotate_half_pairs();
        test_pair_count_zero();
        test_short_head();
        test_mid_head_change();
        test_unknown_register();
        test_backpressure();
        test_random_heads();

        settle();
        if (error_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
